FILE: hw/rtl/tte_pkg.sv
// Package for the transposition table engine: table geometry, command and
// bound codes, and the packed item and slot types shared by all RTL files.
// Depends on nothing.
package tte_pkg;

  // Number of table slots. The slot index is the low bits of the key, so the
  // entry count is a power of two.
  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  typedef logic [IDX_W-1:0] tte_idx_t;

  localparam tte_idx_t IDX_LAST = tte_idx_t'(TABLE_ENTRIES - 1);

  // Command codes.
  localparam logic CMD_PROBE = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  // Bound kinds.
  localparam logic [1:0] FLAG_NONE  = 2'd0;
  localparam logic [1:0] FLAG_EXACT = 2'd1;
  localparam logic [1:0] FLAG_UPPER = 2'd2;
  localparam logic [1:0] FLAG_LOWER = 2'd3;

  // Sequencer states: clearing sweep after reset, then normal operation.
  typedef enum logic {
    TTE_ST_CLEAR,
    TTE_ST_RUN
  } tte_state_t;

  // Input item.
  typedef struct packed {
    logic               command;
    logic        [63:0] key;
    logic signed [7:0]  depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] score_in;
    logic        [15:0] move_in;
    logic        [1:0]  flag_in;
  } tte_in_t;

  // Result item.
  typedef struct packed {
    logic               found;
    logic               usable;
    logic signed [15:0] score_out;
    logic        [15:0] move_out;
    logic        [1:0]  flag_out;
    logic               stored;
    logic        [31:0] probe_count;
    logic        [31:0] hit_count;
  } tte_out_t;

  // One table slot as held in memory.
  typedef struct packed {
    logic        [63:0] key;
    logic signed [15:0] score;
    logic        [15:0] move;
    logic signed [7:0]  depth;
    logic        [1:0]  flag;
    logic        [7:0]  age;
  } tte_slot_t;

endpackage

FILE: hw/rtl/tte_slot_ram.sv
// Slot memory of the transposition table engine: one write port and one read
// port with registered read data. Depends on tte_pkg for the slot and index types.
module tte_slot_ram (
  input  logic               clk,
  input  logic               we,
  input  tte_pkg::tte_idx_t  waddr,
  input  tte_pkg::tte_slot_t wdata,
  input  logic               re,
  input  tte_pkg::tte_idx_t  raddr,
  output tte_pkg::tte_slot_t rdata
);

  tte_pkg::tte_slot_t mem [tte_pkg::TABLE_ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/transposition_table_engine_core.sv
// Top level of the transposition table engine: handshakes, clearing sweep,
// read-modify-write of the slot memory and the probe and hit counters.
// Depends on tte_pkg and tte_slot_ram.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  tte_pkg::tte_in_t in_data
//   out_     output     out_valid/out_stall tte_pkg::tte_out_t out_data
//   cfg_     input      cfg_valid/cfg_ready cfg_data (generation, 8 bits)
//
// One item a cycle is sustained while the output is not stalled. The memory read
// is issued as an item is accepted; the item is evaluated in the next cycle and
// written back as it leaves the evaluate stage, and its result is then offered
// from the output register. A store feeding the next item's read is forwarded
// from a one-entry write register. After reset the memory is cleared one slot a
// cycle, over all TABLE_ENTRIES slots, with in_stall high.
// A stalled output holds the evaluate stage, and in turn stalls the input.
module transposition_table_engine_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tte_pkg::tte_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tte_pkg::tte_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  tte_pkg::tte_state_t state_r, state_nxt;
  tte_pkg::tte_idx_t   clr_cnt_r, clr_cnt_nxt;
  logic                clearing;

  logic [7:0]          gen_r;

  logic                ex_valid_r;
  tte_pkg::tte_in_t    ex_r;
  logic                ex_fire;
  logic                in_accept;

  logic                fwd_valid_r;
  tte_pkg::tte_idx_t   fwd_idx_r;
  tte_pkg::tte_slot_t  fwd_slot_r;

  logic                out_valid_r;
  tte_pkg::tte_out_t   out_data_r;
  tte_pkg::tte_out_t   res;

  logic [31:0]         probe_cnt_r, probe_cnt_nxt;
  logic [31:0]         hit_cnt_r, hit_cnt_nxt;

  tte_pkg::tte_idx_t   ex_idx;
  tte_pkg::tte_slot_t  rd_slot;
  tte_pkg::tte_slot_t  slot_cur;
  tte_pkg::tte_slot_t  slot_new;
  logic                key_hit;
  logic                depth_ok;
  logic                bound_ok;
  logic                store_wr;
  logic                do_write;

  logic                mem_we;
  tte_pkg::tte_idx_t   mem_waddr;
  tte_pkg::tte_slot_t  mem_wdata;

  // Next state of the clearing sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tte_pkg::TTE_ST_CLEAR: begin
        if (clr_cnt_r == tte_pkg::IDX_LAST) begin
          state_nxt = tte_pkg::TTE_ST_RUN;
        end
      end
      tte_pkg::TTE_ST_RUN: begin
        state_nxt = tte_pkg::TTE_ST_RUN;
      end
      default: begin
        state_nxt = tte_pkg::TTE_ST_CLEAR;
      end
    endcase
  end

  // Outputs of the clearing sequencer.
  always_comb begin
    clearing    = 1'b0;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      tte_pkg::TTE_ST_CLEAR: begin
        clearing    = 1'b1;
        clr_cnt_nxt = clr_cnt_r + tte_pkg::tte_idx_t'(1);
      end
      tte_pkg::TTE_ST_RUN: begin
        clearing = 1'b0;
      end
      default: begin
        clearing = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tte_pkg::TTE_ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Configuration register: the generation is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      gen_r <= cfg_data;
    end
  end

  // Handshakes: the evaluate stage moves on when the output register is free.
  assign ex_fire   = ex_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = clearing || (ex_valid_r && !ex_fire);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else if (in_accept) begin
      ex_valid_r <= 1'b1;
    end else if (ex_fire) begin
      ex_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ex_r <= in_data;
    end
  end

  // Slot memory; the read is issued as the item is accepted.
  tte_slot_ram u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_accept),
    .raddr (in_data.key[tte_pkg::IDX_W-1:0]),
    .rdata (rd_slot)
  );

  // The slot written by the previous item may be newer than the memory read.
  assign ex_idx   = ex_r.key[tte_pkg::IDX_W-1:0];
  assign slot_cur = (fwd_valid_r && (fwd_idx_r == ex_idx)) ? fwd_slot_r : rd_slot;

  // Probe evaluation.
  assign key_hit  = (slot_cur.key == ex_r.key);
  assign depth_ok = (slot_cur.depth >= ex_r.depth);

  always_comb begin
    bound_ok = 1'b0;
    unique case (slot_cur.flag)
      tte_pkg::FLAG_EXACT: bound_ok = 1'b1;
      tte_pkg::FLAG_UPPER: bound_ok = (slot_cur.score <= ex_r.alpha);
      tte_pkg::FLAG_LOWER: bound_ok = (slot_cur.score >= ex_r.beta);
      default:             bound_ok = 1'b0;
    endcase
  end

  // A store keeps an entry of another position from this generation that is at least as deep.
  assign store_wr = !((slot_cur.key != 64'd0) && !key_hit &&
                      (slot_cur.age == gen_r) && (ex_r.depth <= slot_cur.depth));
  assign do_write = ex_fire && (ex_r.command == tte_pkg::CMD_STORE) && store_wr;

  always_comb begin
    slot_new.key   = ex_r.key;
    slot_new.score = ex_r.score_in;
    slot_new.move  = ex_r.move_in;
    slot_new.depth = ex_r.depth;
    slot_new.flag  = ex_r.flag_in;
    slot_new.age   = gen_r;
  end

  // Memory write port: clearing sweep first, then store write-backs.
  assign mem_we    = clearing || do_write;
  assign mem_waddr = clearing ? clr_cnt_r : ex_idx;
  assign mem_wdata = clearing ? tte_pkg::tte_slot_t'('0) : slot_new;

  // Forwarding register follows the most recent item's write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (ex_fire) begin
      fwd_valid_r <= do_write;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      fwd_idx_r  <= ex_idx;
      fwd_slot_r <= slot_new;
    end
  end

  // Counters and result item.
  always_comb begin
    probe_cnt_nxt = probe_cnt_r;
    hit_cnt_nxt   = hit_cnt_r;
    res           = '0;
    if (ex_r.command == tte_pkg::CMD_PROBE) begin
      probe_cnt_nxt = probe_cnt_r + 32'd1;
      if (key_hit) begin
        hit_cnt_nxt   = hit_cnt_r + 32'd1;
        res.found     = 1'b1;
        res.usable    = depth_ok && bound_ok;
        res.score_out = slot_cur.score;
        res.move_out  = slot_cur.move;
        res.flag_out  = slot_cur.flag;
      end
    end else begin
      res.stored = store_wr;
    end
    res.probe_count = probe_cnt_nxt;
    res.hit_count   = hit_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_cnt_r <= '0;
      hit_cnt_r   <= '0;
    end else if (ex_fire) begin
      probe_cnt_r <= probe_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ex_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // Outside the clearing sweep only a store that fires writes the memory.
  a_write_only_by_store: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && !clearing) |-> (ex_fire && (ex_r.command == tte_pkg::CMD_STORE)))
    else $error("slot memory written without a firing store");

  // No item is in flight while the table is being cleared.
  a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !ex_valid_r)
    else $error("item in flight during clearing sweep");

  // A finished item always reaches the output register.
  a_fire_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire |=> out_valid_r)
    else $error("evaluated item lost before the output register");

  // A usable result is always a hit, and a store never reports a hit.
  a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_data_r.usable || out_data_r.found) &&
                     !(out_data_r.stored && out_data_r.found)))
    else $error("inconsistent result item");
`endif

endmodule
